>>> design/rlru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlru_pkg
// Shared types and command codes for the recent items LRU list unit.
// ----------------------------------------------------------------------------
package rlru_pkg;

  localparam int IdW    = 16;
  localparam int CmdW   = 2;
  localparam int CountW = 5;

  localparam logic [CmdW-1:0] CMD_VIEW   = 2'd0;
  localparam logic [CmdW-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CmdW-1:0] CMD_CLEAR  = 2'd2;

  // one request: command and item id
  typedef struct packed {
    logic [CmdW-1:0] command;
    logic [IdW-1:0]  item_id;
  } in_t;

  // one result
  typedef struct packed {
    logic              hit;
    logic              evicted_valid;
    logic [IdW-1:0]    evicted_id;
    logic [CountW-1:0] active_count;
  } out_t;

  // finished result offered by the controller to the output stage
  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

endpackage

>>> design/rlru_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlru_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rlru_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/rlru_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlru_ctrl
// Command sequencer: scans the id memory one slot a cycle, compacts the list
// behind a matched or evicted slot, and writes the newest id at the tail.
// ----------------------------------------------------------------------------
module rlru_ctrl #(
  parameter int HISTORY_LIMIT = 16,
  localparam int AW = (HISTORY_LIMIT > 1) ? $clog2(HISTORY_LIMIT) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  rlru_pkg::in_t        req,
  output logic                 req_stall,
  output rlru_pkg::res_t       res,
  input  logic                 res_take,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output logic [rlru_pkg::IdW-1:0] mem_wdata,
  output logic                 mem_re,
  output logic [AW-1:0]        mem_raddr,
  input  logic [rlru_pkg::IdW-1:0] mem_rdata
);

  import rlru_pkg::*;

  localparam int CW = $clog2(HISTORY_LIMIT + 1);
  localparam logic [CW-1:0] Limit = CW'(HISTORY_LIMIT);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]      state;
  logic [CW-1:0]   count;
  logic [CmdW-1:0] cmd;
  logic [IdW-1:0]  id;
  logic [CW-1:0]   rd_addr;
  logic            pend;
  logic [AW-1:0]   pend_addr;
  logic            found;
  logic            shift_mode;
  logic            hit;
  logic            evicted;
  logic [IdW-1:0]  evict_id;

  logic            accept;
  logic            issue;
  logic            pmatch;
  logic            pshift;
  logic            found_now;
  logic            scan_done;
  logic [CW-1:0]   wslot;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != ST_IDLE);

  // scan datapath: issue reads ahead, examine the returning slot
  assign issue     = (state == ST_SCAN) && (rd_addr < count);
  assign pmatch    = pend && !found && !shift_mode && (mem_rdata == id);
  assign pshift    = pend && (found || shift_mode);
  assign found_now = found || pmatch;
  assign scan_done = (state == ST_SCAN) && !(rd_addr < count);

  // tail slot for the new id
  assign wslot = (hit || evicted) ? (count - CW'(1)) : count;

  assign mem_re    = issue;
  assign mem_raddr = rd_addr[AW-1:0];
  assign mem_we    = ((state == ST_SCAN) && pshift) || (state == ST_WRITE);
  assign mem_waddr = (state == ST_WRITE) ? wslot[AW-1:0] : (pend_addr - AW'(1));
  assign mem_wdata = (state == ST_WRITE) ? id : mem_rdata;

  // offer the result
  assign res.valid               = (state == ST_DONE);
  assign res.data.hit            = hit;
  assign res.data.evicted_valid  = evicted;
  assign res.data.evicted_id     = evicted ? evict_id : '0;
  assign res.data.active_count   = CountW'(count);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      pend       <= 1'b0;
      found      <= 1'b0;
      shift_mode <= 1'b0;
      hit        <= 1'b0;
      evicted    <= 1'b0;
      rd_addr    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd        <= req.command;
            id         <= req.item_id;
            rd_addr    <= '0;
            pend       <= 1'b0;
            found      <= 1'b0;
            shift_mode <= 1'b0;
            hit        <= 1'b0;
            evicted    <= 1'b0;
            if (req.command == CMD_CLEAR) begin
              count <= '0;
              state <= ST_DONE;
            end else if (req.command == CMD_VIEW || req.command == CMD_REMOVE) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_SCAN: begin
          // advance the read pointer
          pend <= issue;
          if (issue) begin
            pend_addr <= rd_addr[AW-1:0];
            rd_addr   <= rd_addr + CW'(1);
          end
          if (pmatch) begin
            found <= 1'b1;
          end
          // hold the oldest id in case the list must drop it
          if (pend && !shift_mode && pend_addr == '0) begin
            evict_id <= mem_rdata;
          end
          if (scan_done) begin
            if (shift_mode) begin
              state <= ST_WRITE;
            end else if (cmd == CMD_VIEW) begin
              if (found_now) begin
                hit   <= 1'b1;
                state <= ST_WRITE;
              end else if (count < Limit) begin
                state <= ST_WRITE;
              end else begin
                // full: drop the oldest by compacting from slot one
                evicted    <= 1'b1;
                shift_mode <= 1'b1;
                rd_addr    <= CW'(1);
              end
            end else begin
              if (found_now) begin
                hit   <= 1'b1;
                count <= count - CW'(1);
              end
              state <= ST_DONE;
            end
          end
        end
        ST_WRITE: begin
          if (!hit && !evicted) begin
            count <= count + CW'(1);
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // the fill count never passes the list depth
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    count <= Limit)
    else $error("active count above list depth");

  // compaction writes always trail the read pointer
  a_write_trails: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state == ST_SCAN) |-> (CW'(mem_waddr) < rd_addr))
    else $error("compaction write overtook read");

  // a clear empties the list at once
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && req.command == CMD_CLEAR) |=> (count == '0))
    else $error("clear did not empty list");

  // no memory write while idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !mem_we)
    else $error("memory write while idle");

endmodule

>>> design/recent_items_lru_list_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recent_items_lru_list_unit
// Recency-ordered list of active item ids kept compact in one id memory.
// ----------------------------------------------------------------------------
// Sequence from accept to result: a view scans the live slots (one memory
//   read per live slot) and then writes the new id at the tail; a remove only
//   scans; a view that evicts from a full list compacts again from slot one
//   before the write; clear and unused codes go straight to the result.
// Throughput: one request at a time; the next one is accepted only after the
//   result has moved to the output register.
// Reset: clears the fill count and control; the id memory is not cleared, the
//   fill count marks slots 0..count-1 as live.
// ----------------------------------------------------------------------------
module recent_items_lru_list_unit #(
  parameter int HISTORY_LIMIT = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  rlru_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output rlru_pkg::out_t out_data
);

  import rlru_pkg::*;

  localparam int AW = (HISTORY_LIMIT > 1) ? $clog2(HISTORY_LIMIT) : 1;

  res_t           res;
  logic           res_take;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [IdW-1:0] mem_wdata;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;
  logic [IdW-1:0] mem_rdata;

  rlru_ctrl #(
    .HISTORY_LIMIT(HISTORY_LIMIT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (in_valid),
    .req       (in_data),
    .req_stall (in_stall),
    .res       (res),
    .res_take  (res_take),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  rlru_ram #(
    .WIDTH(IdW),
    .DEPTH(HISTORY_LIMIT)
  ) u_ids (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // load the output register when it is empty or being drained
  assign res_take = res.valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= res.data;
    end
  end

endmodule

>>> tb/sv/tb_recent_items_lru_list_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_recent_items_lru_list_unit
// Self-checking bench for the recent items LRU list: a queue-fed driver
// offers view, remove, clear and unused-code requests, a shadow recency list
// predicts each answer, and a monitor compares every answer field by field
// while both sides idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb_recent_items_lru_list_unit;
  import rlru_pkg::*;

  localparam int HistLimit      = 16;
  localparam int RandomReqs     = 500;
  localparam int QuietTail      = 60;
  localparam int LongHoldAt     = 120;
  localparam int LongHoldCycles = 300;
  localparam int DrainAt        = 300;
  localparam int SettleCycles   = 60;
  localparam int CycleLimit     = 200000;
  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    in_t req;
    bit  drain_first;
  } pending_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  pending_t      pending_reqs[$];
  out_t          expected_answers[$];
  logic [IdW-1:0] recency_list[$];
  logic [IdW-1:0] id_pool[24];

  int unsigned accepted_cnt = 0;
  int unsigned answered_cnt = 0;
  int unsigned cycle_cnt    = 0;
  int          gap_left     = 0;
  int          stall_left   = 0;
  bit          long_hold_done = 1'b0;
  int          error_count  = 0;

  recent_items_lru_list_unit #(
    .HISTORY_LIMIT(HistLimit)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Apply one request to the shadow recency list and queue its answer
  function automatic void apply_to_recency_list(input in_t req);
    out_t ans;
    int   pos;
    ans = '0;
    pos = -1;
    foreach (recency_list[i]) begin
      if (recency_list[i] == req.item_id) pos = i;
    end
    case (req.command)
      CMD_VIEW: begin
        if (pos >= 0) begin
          ans.hit = 1'b1;
          recency_list.delete(pos);
        end else if (recency_list.size() >= HistLimit) begin
          ans.evicted_valid = 1'b1;
          ans.evicted_id    = recency_list.pop_front();
        end
        recency_list.push_back(req.item_id);
      end
      CMD_REMOVE: begin
        if (pos >= 0) begin
          ans.hit = 1'b1;
          recency_list.delete(pos);
        end
      end
      CMD_CLEAR: begin
        recency_list.delete();
      end
      default: begin
      end
    endcase
    ans.active_count = CountW'(recency_list.size());
    expected_answers.push_back(ans);
  endfunction

  function automatic void queue_req(input logic [CmdW-1:0] cmd, input logic [IdW-1:0] id,
                                    input bit drain);
    pending_t p;
    p.req.command = cmd;
    p.req.item_id = id;
    p.drain_first = drain;
    pending_reqs.push_back(p);
  endfunction

  // Driver: predict on accept, hold while stalled, insert random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_to_recency_list(in_data);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (in_valid && in_stall) begin
        // hold the offered request
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (in_valid && pending_reqs.size() > QuietTail &&
                   $urandom_range(0, 5) == 0) begin
        gap_left <= $urandom_range(0, 14);
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0 &&
                   (!pending_reqs[0].drain_first ||
                    (!in_valid && accepted_cnt == answered_cnt))) begin
        in_data  <= pending_reqs[0].req;
        in_valid <= 1'b1;
        pending_reqs.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: one long hold-off, then random bursts, quiet at the end
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (!long_hold_done && accepted_cnt >= LongHoldAt) begin
      long_hold_done <= 1'b1;
      stall_left     <= LongHoldCycles;
      out_stall      <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (pending_reqs.size() > QuietTail && (accepted_cnt / 64) % 3 != 2 &&
                 $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: compare each accepted answer with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_answers.size() == 0) begin
        $error("unexpected answer: hit %0d evicted_valid %0d evicted_id %0h active_count %0d",
               out_data.hit, out_data.evicted_valid, out_data.evicted_id,
               out_data.active_count);
        error_count++;
      end else begin
        if (out_data.hit !== expected_answers[0].hit) begin
          $error("hit: expected %0d, got %0d", expected_answers[0].hit, out_data.hit);
          error_count++;
        end
        if (out_data.evicted_valid !== expected_answers[0].evicted_valid) begin
          $error("evicted_valid: expected %0d, got %0d",
                 expected_answers[0].evicted_valid, out_data.evicted_valid);
          error_count++;
        end
        if (out_data.evicted_id !== expected_answers[0].evicted_id) begin
          $error("evicted_id: expected %0h, got %0h",
                 expected_answers[0].evicted_id, out_data.evicted_id);
          error_count++;
        end
        if (out_data.active_count !== expected_answers[0].active_count) begin
          $error("active_count: expected %0d, got %0d",
                 expected_answers[0].active_count, out_data.active_count);
          error_count++;
        end
        expected_answers.pop_front();
        answered_cnt <= answered_cnt + 1;
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Fill the request queue, release reset, wait for the last answer
  initial begin
    int unsigned r;
    logic [CmdW-1:0] cmd;
    logic [IdW-1:0]  id;

    foreach (id_pool[i]) id_pool[i] = IdW'($urandom);

    // directed: empty-list corners, extreme ids, hit and move, fill and evict
    queue_req(CMD_CLEAR, 16'hFFFF, 1'b0);
    queue_req(CMD_UNUSED, 16'h0000, 1'b0);
    queue_req(CMD_REMOVE, 16'h0000, 1'b0);
    queue_req(CMD_VIEW, 16'h0000, 1'b0);
    queue_req(CMD_VIEW, 16'hFFFF, 1'b0);
    queue_req(CMD_VIEW, 16'h0000, 1'b0);
    queue_req(CMD_REMOVE, 16'hFFFF, 1'b0);
    for (int k = 1; k <= 16; k++) begin
      queue_req(CMD_VIEW, {k[7:0], ~k[7:0]}, 1'b0);
    end
    // oldest of a full list moves to newest, then drop one from the middle
    queue_req(CMD_VIEW, {8'd1, ~8'd1}, 1'b0);
    queue_req(CMD_REMOVE, {8'd8, ~8'd8}, 1'b0);
    queue_req(CMD_UNUSED, 16'hFFFF, 1'b0);
    queue_req(CMD_CLEAR, 16'h5A5A, 1'b1);

    // random: mostly views over a small id pool so the list fills and hits
    for (int n = 0; n < RandomReqs; n++) begin
      r = $urandom_range(0, 99);
      if (r < 72)      cmd = CMD_VIEW;
      else if (r < 92) cmd = CMD_REMOVE;
      else if (r < 94) cmd = CMD_CLEAR;
      else             cmd = CMD_UNUSED;
      if ($urandom_range(0, 6) == 0) id = IdW'($urandom);
      else                           id = id_pool[$urandom_range(0, 23)];
      queue_req(cmd, id, n == DrainAt);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || accepted_cnt != answered_cnt);
    repeat (SettleCycles) @(posedge clk);

    if (error_count == 0 && expected_answers.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
